@@ hw/rtl/tbma_pkg.sv @@
// Shared types and constants for the timing bin mean accumulator.
package tbma_pkg;

  localparam int DEF_POSITIONS  = 16;
  localparam int DEF_MAX_SETS   = 64;
  localparam int DEF_COUNT_BITS = 24;

  // Byte values per position, and bits below the binary point of a mean.
  localparam int VALUES    = 256;
  localparam int FRAC_BITS = 8;
  localparam int DEV_W     = 25;
  localparam int TIMING_W  = 16;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_TIMING = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

endpackage

@@ hw/rtl/tbma_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module tbma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/tbma_div.sv @@
// Bit-serial restoring divider that returns the low bits of the quotient.
module tbma_div #(
  parameter int DVD_W = 48,
  parameter int DSR_W = 24,
  parameter int Q_W   = 25
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             done,
  output logic [Q_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DSR_W:0]   rem_r, rem_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DSR_W-1:0] dsr_r, dsr_nxt;
  logic [Q_W-1:0]   q_r, q_nxt;
  logic [DSR_W:0]   shifted;
  logic [DSR_W:0]   diff;

  assign shifted = {rem_r[DSR_W-1:0], dvd_r[DVD_W-1]};
  assign diff    = shifted - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      q_nxt    = '0;
    end else if (busy_r) begin
      // One quotient bit per cycle, most significant first.
      if (shifted >= {1'b0, dsr_r}) begin
        rem_nxt = diff;
        q_nxt   = {q_r[Q_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[Q_W-2:0], 1'b0};
      end
      dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

@@ hw/rtl/timing_bin_mean_accumulator_unit.sv @@
// Top level of the timing bin mean accumulator: sequencer, stores and query path.
//
// The block tallies cache probe timings by plaintext byte value. A load transaction
// stores one plaintext byte and leaves the input unstalled. A timing transaction adds
// its timing, with a count of one, to the bin of every byte position at that
// position's current byte value and once to the set total; the bin memory has one
// read and one write port, so the read-modify-writes are overlapped one position per
// cycle and a timing transaction keeps the input stalled until its last write-back.
// A query transaction reads the bin and the set entry, then computes both means
// (sum*256/count, truncated) with one shared bit-serial divider, and keeps the input
// stalled until its result is in the output register; a query on an empty bin or
// set skips the divisions.
// A result waiting in the output register does not block further loads or timings.
// After reset the block sweeps the bin and set memories to zero, one entry per
// cycle, while in_stall is high. A saturated count freezes its entry; an empty bin
// or set, or an out-of-range position or set, yields deviation 0 with out_valid_res
// low.
module timing_bin_mean_accumulator_unit
  import tbma_pkg::*;
#(
  parameter int POSITIONS  = DEF_POSITIONS,
  parameter int MAX_SETS   = DEF_MAX_SETS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_func,
  input  logic [3:0]              in_byte_position,
  input  logic [7:0]              in_byte_value,
  input  logic [5:0]              in_set_index,
  input  logic [15:0]             in_timing,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [DEV_W-1:0] out_deviation,
  output logic                    out_valid_res
);

  localparam int SUM_BITS  = COUNT_BITS + TIMING_W;
  localparam int ENT_W     = SUM_BITS + COUNT_BITS;
  localparam int BIN_DEPTH = POSITIONS * VALUES * MAX_SETS;
  localparam int AW        = $clog2(BIN_DEPTH);
  localparam int SW        = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int PW        = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  localparam int CW        = $clog2(POSITIONS + 1);
  localparam int DVD_W     = SUM_BITS + FRAC_BITS;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    ST_CLR  = 7'b0000001,
    ST_IDLE = 7'b0000010,
    ST_TIM  = 7'b0000100,
    ST_QRD  = 7'b0001000,
    ST_DIVB = 7'b0010000,
    ST_DIVS = 7'b0100000,
    ST_QOUT = 7'b1000000
  } state_t;

  // Memory entries are packed as {sum, count}.
  function automatic logic [AW-1:0] bin_addr(input logic [PW-1:0] p,
                                             input logic [7:0] v,
                                             input logic [SW-1:0] s);
    bin_addr = AW'(p) * AW'(VALUES * MAX_SETS) + AW'(v) * AW'(MAX_SETS) + AW'(s);
  endfunction

  function automatic logic [ENT_W-1:0] upd(input logic [ENT_W-1:0] e,
                                           input logic [TIMING_W-1:0] t);
    logic [SUM_BITS-1:0]   s;
    logic [COUNT_BITS-1:0] c;
    s = e[ENT_W-1:COUNT_BITS];
    c = e[COUNT_BITS-1:0];
    if (c != {COUNT_BITS{1'b1}}) begin
      c = c + 1'b1;
      s = s + SUM_BITS'(t);
    end
    upd = {s, c};
  endfunction

  state_t               state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [AW-1:0]        clr_r, clr_nxt;
  logic                 pend_r, pend_nxt;
  logic                 setw_r, setw_nxt;
  logic [7:0]           pt_r [POSITIONS];
  logic                 out_valid_r, out_valid_nxt;

  logic [SW-1:0]        set_r, set_nxt;
  logic [TIMING_W-1:0]  tim_r, tim_nxt;
  logic [AW-1:0]        waddr_r, waddr_nxt;
  logic [DEV_W-1:0]     bm_r, bm_nxt;
  logic [ENT_W-1:0]     hold_r, hold_nxt;
  logic [DEV_W-1:0]     res_dev_r, res_dev_nxt;
  logic                 res_ok_r, res_ok_nxt;
  logic [DEV_W-1:0]     out_dev_r;
  logic                 out_ok_r;

  logic                 bin_we, set_we;
  logic [AW-1:0]        bin_waddr, bin_raddr;
  logic [SW-1:0]        set_waddr, set_raddr;
  logic [ENT_W-1:0]     bin_wdata, set_wdata, bin_rdata, set_rdata;

  logic                 div_start, div_done;
  logic [DVD_W-1:0]     div_dvd;
  logic [COUNT_BITS-1:0] div_dsr;
  logic [DEV_W-1:0]     div_q;

  logic                 acc, pos_ok, set_ok, out_load;
  logic [PW-1:0]        tim_idx;

  assign acc      = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);
  assign pos_ok   = int'(in_byte_position) < POSITIONS;
  assign set_ok   = int'(in_set_index) < MAX_SETS;
  assign tim_idx  = (int'(cnt_r) < POSITIONS) ? cnt_r[PW-1:0] : '0;
  assign out_load = (state_r == ST_QOUT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    clr_nxt     = clr_r;
    pend_nxt    = 1'b0;
    setw_nxt    = 1'b0;
    set_nxt     = set_r;
    tim_nxt     = tim_r;
    waddr_nxt   = waddr_r;
    bm_nxt      = bm_r;
    hold_nxt    = hold_r;
    res_dev_nxt = res_dev_r;
    res_ok_nxt  = res_ok_r;
    bin_we      = 1'b0;
    bin_waddr   = waddr_r;
    bin_wdata   = upd(bin_rdata, tim_r);
    bin_raddr   = '0;
    set_we      = 1'b0;
    set_waddr   = set_r;
    set_wdata   = upd(set_rdata, tim_r);
    set_raddr   = set_r;
    div_start   = 1'b0;
    div_dvd     = {bin_rdata[ENT_W-1:COUNT_BITS], {FRAC_BITS{1'b0}}};
    div_dsr     = bin_rdata[COUNT_BITS-1:0];

    unique case (state_r)
      ST_CLR: begin
        // Zero one bin entry, and one set entry while in range, per cycle.
        bin_we    = 1'b1;
        bin_waddr = clr_r;
        bin_wdata = '0;
        set_we    = int'(clr_r) < MAX_SETS;
        set_waddr = SW'(clr_r);
        set_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == AW'(BIN_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // Reads issued here land in the first cycle of the next state.
        bin_raddr = bin_addr(PW'(in_byte_position), in_byte_value, SW'(in_set_index));
        set_raddr = SW'(in_set_index);
        if (acc) begin
          set_nxt = SW'(in_set_index);
          tim_nxt = in_timing;
          unique case (func_t'(in_func))
            FUNC_TIMING: begin
              if (set_ok) begin
                state_nxt = ST_TIM;
                cnt_nxt   = '0;
                setw_nxt  = 1'b1;
              end
            end
            FUNC_QUERY: begin
              if (pos_ok && set_ok) begin
                state_nxt = ST_QRD;
              end else begin
                res_dev_nxt = '0;
                res_ok_nxt  = 1'b0;
                state_nxt   = ST_QOUT;
              end
            end
            FUNC_LOAD, FUNC_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_TIM: begin
        // Read position cnt_r while writing back the position before it.
        bin_raddr = bin_addr(tim_idx, pt_r[tim_idx], set_r);
        bin_we    = pend_r;
        set_we    = setw_r;
        if (int'(cnt_r) < POSITIONS) begin
          pend_nxt  = 1'b1;
          waddr_nxt = bin_raddr;
          cnt_nxt   = cnt_r + 1'b1;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_QRD: begin
        if (bin_rdata[COUNT_BITS-1:0] == '0 || set_rdata[COUNT_BITS-1:0] == '0) begin
          res_dev_nxt = '0;
          res_ok_nxt  = 1'b0;
          state_nxt   = ST_QOUT;
        end else begin
          div_start = 1'b1;
          hold_nxt  = set_rdata;
          state_nxt = ST_DIVB;
        end
      end
      ST_DIVB: begin
        div_dvd = {hold_r[ENT_W-1:COUNT_BITS], {FRAC_BITS{1'b0}}};
        div_dsr = hold_r[COUNT_BITS-1:0];
        if (div_done) begin
          bm_nxt    = div_q;
          div_start = 1'b1;
          state_nxt = ST_DIVS;
        end
      end
      ST_DIVS: begin
        if (div_done) begin
          res_dev_nxt = bm_r - div_q;
          res_ok_nxt  = 1'b1;
          state_nxt   = ST_QOUT;
        end
      end
      ST_QOUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      setw_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < POSITIONS; i++) begin
        pt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      setw_r      <= setw_nxt;
      out_valid_r <= out_valid_nxt;
      if (acc && func_t'(in_func) == FUNC_LOAD && pos_ok) begin
        pt_r[PW'(in_byte_position)] <= in_byte_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    set_r     <= set_nxt;
    tim_r     <= tim_nxt;
    waddr_r   <= waddr_nxt;
    bm_r      <= bm_nxt;
    hold_r    <= hold_nxt;
    res_dev_r <= res_dev_nxt;
    res_ok_r  <= res_ok_nxt;
    if (out_load) begin
      out_dev_r <= res_dev_r;
      out_ok_r  <= res_ok_r;
    end
  end

  tbma_ram #(.WIDTH(ENT_W), .DEPTH(BIN_DEPTH)) u_bin_ram (
    .clk   (clk),
    .we    (bin_we),
    .waddr (bin_waddr),
    .wdata (bin_wdata),
    .raddr (bin_raddr),
    .rdata (bin_rdata)
  );

  tbma_ram #(.WIDTH(ENT_W), .DEPTH(MAX_SETS)) u_set_ram (
    .clk   (clk),
    .we    (set_we),
    .waddr (set_waddr),
    .wdata (set_wdata),
    .raddr (set_raddr),
    .rdata (set_rdata)
  );

  tbma_div #(.DVD_W(DVD_W), .DSR_W(COUNT_BITS), .Q_W(DEV_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_valid     = out_valid_r;
  assign out_deviation = out_dev_r;
  assign out_valid_res = out_ok_r;

endmodule

@@ hw/rtl/tbma_checker.sv @@
// Port-level assertions for the timing bin mean accumulator, with their bind.
module tbma_checker
  import tbma_pkg::*;
#(
  parameter int MAX_SETS = DEF_MAX_SETS
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic [1:0]              in_func,
  input logic [5:0]              in_set_index,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [DEV_W-1:0] out_deviation,
  input logic                    out_valid_res
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_deviation) &&
                               $stable(out_valid_res))
    else $error("stalled result changed");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_deviation == '0)
    else $error("invalid result carries a nonzero deviation");

  a_timing_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_func == FUNC_TIMING && int'(in_set_index) < MAX_SETS
    |=> in_stall)
    else $error("timing transaction did not occupy the block");

  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_func == FUNC_LOAD |=> !in_stall)
    else $error("load transaction stalled the input");

endmodule

bind timing_bin_mean_accumulator_unit tbma_checker #(.MAX_SETS(MAX_SETS)) u_tbma_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_func       (in_func),
  .in_set_index  (in_set_index),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_deviation (out_deviation),
  .out_valid_res (out_valid_res)
);

@@ tb/sv/timing_bin_mean_accumulator_unit_tb.sv @@
// Self-checking testbench for the timing bin mean accumulator top level.
`timescale 1ns / 1ps

module timing_bin_mean_accumulator_unit_tb;
  import tbma_pkg::*;

  localparam int NPOS      = DEF_POSITIONS;
  localparam int NSETS     = DEF_MAX_SETS;
  localparam int CNT_MAX   = (1 << DEF_COUNT_BITS) - 1;
  localparam int CLEAR_CYC = NPOS * VALUES * NSETS;
  // The longest quiet stretch of a correct run is the clearing sweep after reset;
  // the limit sits several times above it.
  localparam int WATCHDOG  = 4 * CLEAR_CYC;
  localparam int N_RANDOM  = 450;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [1:0]              in_func;
  logic [3:0]              in_byte_position;
  logic [7:0]              in_byte_value;
  logic [5:0]              in_set_index;
  logic [15:0]             in_timing;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [DEV_W-1:0] out_deviation;
  logic                    out_valid_res;

  timing_bin_mean_accumulator_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_byte_position (in_byte_position),
    .in_byte_value    (in_byte_value),
    .in_set_index     (in_set_index),
    .in_timing        (in_timing),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_deviation    (out_deviation),
    .out_valid_res    (out_valid_res)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  typedef struct packed {
    logic [DEV_W-1:0] deviation;
    logic             valid_res;
  } tally_result_t;

  // Shadow copy of the tally. The bin store is sparse, so an associative array keyed
  // by position, value and set keeps only the bins that were actually touched.
  logic [7:0]  shadow_bytes [NPOS];
  logic [39:0] shadow_bin_sum [int];
  int unsigned shadow_bin_cnt [int];
  logic [39:0] shadow_set_sum [NSETS];
  int unsigned shadow_set_cnt [NSETS];

  tally_result_t pending_deviations [$];

  int unsigned fail_count;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          done;

  function automatic int bin_key(int p, int v, int s);
    return (p * VALUES + v) * NSETS + s;
  endfunction

  // Applies one accepted transaction to the shadow tally and returns the expected
  // result of a query.
  function automatic tally_result_t tally_apply(logic [1:0] fn, logic [3:0] pos,
                                                logic [7:0] val, logic [5:0] set,
                                                logic [15:0] tim);
    tally_result_t r;
    int          k;
    logic [63:0] bin_mean;
    logic [63:0] set_mean;
    r = '0;
    case (func_t'(fn))
      FUNC_LOAD: begin
        shadow_bytes[pos] = val;
      end
      FUNC_TIMING: begin
        if (shadow_set_cnt[set] < CNT_MAX) begin
          shadow_set_cnt[set]++;
          shadow_set_sum[set] += tim;
        end
        for (int p = 0; p < NPOS; p++) begin
          k = bin_key(p, shadow_bytes[p], set);
          if (!shadow_bin_cnt.exists(k)) begin
            shadow_bin_cnt[k] = 0;
            shadow_bin_sum[k] = '0;
          end
          if (shadow_bin_cnt[k] < CNT_MAX) begin
            shadow_bin_cnt[k]++;
            shadow_bin_sum[k] += tim;
          end
        end
      end
      FUNC_QUERY: begin
        k = bin_key(pos, val, set);
        if (shadow_bin_cnt.exists(k) && shadow_bin_cnt[k] != 0 &&
            shadow_set_cnt[set] != 0) begin
          bin_mean = ({24'd0, shadow_bin_sum[k]} << FRAC_BITS) / shadow_bin_cnt[k];
          set_mean = ({24'd0, shadow_set_sum[set]} << FRAC_BITS) / shadow_set_cnt[set];
          r.deviation = DEV_W'(bin_mean - set_mean);
          r.valid_res = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Sends one transaction: waits for acceptance and leaves valid high, so that the
  // next transaction either overwrites the payload on the following edge or drops
  // valid while it idles.
  task automatic send_txn(logic [1:0] fn, logic [3:0] pos, logic [7:0] val,
                          logic [5:0] set, logic [15:0] tim);
    tally_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_func          <= fn;
    in_byte_position <= pos;
    in_byte_value    <= val;
    in_set_index     <= set;
    in_timing        <= tim;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = tally_apply(fn, pos, val, set, tim);
    if (func_t'(fn) == FUNC_QUERY) pending_deviations.push_back(r);
  endtask

  // The receiver stalls at random; every accepted result is compared against the
  // oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_deviations.size() == 0) begin
          $display("%0t: unexpected result deviation=%0d valid_res=%0b", $time,
                   out_deviation, out_valid_res);
          fail_count++;
        end else begin
          tally_result_t e;
          e = pending_deviations.pop_front();
          if (out_deviation !== e.deviation) begin
            $display("%0t: deviation expected %0d actual %0d", $time,
                     $signed(e.deviation), out_deviation);
            fail_count++;
          end
          if (out_valid_res !== e.valid_res) begin
            $display("%0t: valid_res expected %0b actual %0b", $time, e.valid_res,
                     out_valid_res);
            fail_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on cycles in which no transaction moves on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (!done && idle_cycles >= WATCHDOG) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Directed rows. Expected values sit in directed_exp and are only used where its
  // check bit is set; those rows have answers obvious from the rule for an empty bin or set, or from equal means.
  typedef struct packed {
    logic [1:0]  fn;
    logic [3:0]  pos;
    logic [7:0]  val;
    logic [5:0]  set;
    logic [15:0] tim;
  } stim_row_t;

  localparam int N_DIRECTED = 22;
  stim_row_t directed_rows [N_DIRECTED] = '{
    // Queries on an empty tally, including the extreme position, value and set.
    '{FUNC_QUERY,  4'd0,  8'd0,   6'd0,  16'd0},
    '{FUNC_QUERY,  4'd15, 8'd255, 6'd63, 16'hffff},
    // Load extreme bytes, then tally extreme timings into the extreme sets.
    '{FUNC_LOAD,   4'd0,  8'd255, 6'd0,  16'd0},
    '{FUNC_LOAD,   4'd15, 8'd255, 6'd63, 16'd0},
    '{FUNC_LOAD,   4'd7,  8'd128, 6'd0,  16'd0},
    '{FUNC_TIMING, 4'd0,  8'd0,   6'd63, 16'hffff},
    '{FUNC_TIMING, 4'd0,  8'd0,   6'd63, 16'd0},
    '{FUNC_TIMING, 4'd0,  8'd0,   6'd0,  16'd1},
    '{FUNC_QUERY,  4'd0,  8'd255, 6'd63, 16'd0},
    '{FUNC_QUERY,  4'd15, 8'd255, 6'd63, 16'd0},
    '{FUNC_QUERY,  4'd1,  8'd0,   6'd63, 16'd0},
    '{FUNC_QUERY,  4'd7,  8'd128, 6'd0,  16'd0},
    // A different byte value makes the bin mean drift from the set mean.
    '{FUNC_LOAD,   4'd0,  8'd3,   6'd0,  16'd0},
    '{FUNC_TIMING, 4'd0,  8'd0,   6'd63, 16'd300},
    '{FUNC_QUERY,  4'd0,  8'd3,   6'd63, 16'd0},
    '{FUNC_QUERY,  4'd0,  8'd255, 6'd63, 16'd0},
    // Empty bin in a populated set, and the unused function code.
    '{FUNC_QUERY,  4'd5,  8'd77,  6'd63, 16'd0},
    '{FUNC_NONE,   4'd15, 8'd255, 6'd63, 16'hffff},
    '{FUNC_QUERY,  4'd7,  8'd128, 6'd63, 16'd0},
    '{FUNC_TIMING, 4'd0,  8'd0,   6'd0,  16'hffff},
    '{FUNC_QUERY,  4'd15, 8'd255, 6'd0,  16'd0},
    '{FUNC_QUERY,  4'd0,  8'd0,   6'd32, 16'd0}
  };

  // Each row: check enable, expected deviation, expected valid_res.
  logic [DEV_W+1:0] directed_exp [N_DIRECTED];

  initial begin
    int unsigned   phase;
    int unsigned   fn_pick;
    tally_result_t r;
    int unsigned   n_q;

    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_func          = FUNC_LOAD;
    in_byte_position = '0;
    in_byte_value    = '0;
    in_set_index     = '0;
    in_timing        = '0;
    out_stall        = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    fail_count       = 0;
    idle_cycles      = 0;
    done             = 1'b0;
    foreach (shadow_bytes[i]) shadow_bytes[i] = '0;
    foreach (shadow_set_sum[i]) begin
      shadow_set_sum[i] = '0;
      shadow_set_cnt[i] = 0;
    end
    foreach (directed_exp[i]) directed_exp[i] = '0;
    // Empty-tally and empty-bin rows are known without any arithmetic.
    directed_exp[0]  = {1'b1, {DEV_W{1'b0}}, 1'b0};
    directed_exp[1]  = {1'b1, {DEV_W{1'b0}}, 1'b0};
    directed_exp[16] = {1'b1, {DEV_W{1'b0}}, 1'b0};
    // This bin saw every timing of its set, so both means are the same.
    directed_exp[18] = {1'b1, {DEV_W{1'b0}}, 1'b1};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    n_q = 0;
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_txn(directed_rows[i].fn, directed_rows[i].pos, directed_rows[i].val,
               directed_rows[i].set, directed_rows[i].tim);
      // For rows with a typed-in answer, the predictor must agree with the table.
      if (func_t'(directed_rows[i].fn) == FUNC_QUERY && directed_exp[i][DEV_W+1]) begin
        r = pending_deviations[pending_deviations.size() - 1];
        if ({r.deviation, r.valid_res} !== directed_exp[i][DEV_W:0]) begin
          $display("%0t: row %0d expected %0d/%0b predicted %0d/%0b", $time, i,
                   $signed(directed_exp[i][DEV_W:1]), directed_exp[i][0],
                   $signed(r.deviation), r.valid_res);
          fail_count++;
        end
      end
    end

    // Random part in four pressure phases. Transactions are picked at random among
    // byte loads, timings mostly into a small pool of sets so that bins fill up, and
    // queries mostly aimed at loaded values so that many hit populated bins.
    for (int i = 0; i < N_RANDOM; i++) begin
      phase = (i * 4) / N_RANDOM;
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      // Short bursts without any idling inside every phase.
      if ($urandom_range(9) == 0) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      fn_pick = $urandom_range(99);
      if (fn_pick < 35) begin
        send_txn(FUNC_LOAD, 4'($urandom_range(15)), 8'($urandom_range(3) == 0 ?
                 $urandom_range(255) : $urandom_range(3)), 6'($urandom), 16'($urandom));
      end else if (fn_pick < 65) begin
        send_txn(FUNC_TIMING, 4'($urandom), 8'($urandom),
                 6'($urandom_range(4) == 0 ? $urandom_range(63) : $urandom_range(3)),
                 16'($urandom_range(1) ? $urandom : $urandom_range(900, 1100)));
      end else if (fn_pick < 97) begin
        int p;
        p = $urandom_range(15);
        send_txn(FUNC_QUERY, 4'(p),
                 $urandom_range(3) == 0 ? 8'($urandom) : shadow_bytes[p],
                 6'($urandom_range(4) == 0 ? $urandom_range(63) : $urandom_range(3)),
                 16'($urandom));
      end else begin
        send_txn(FUNC_NONE, 4'($urandom), 8'($urandom), 6'($urandom), 16'($urandom));
      end
    end

    in_valid       <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (pending_deviations.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    done = 1'b1;
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
